// ===== design/crc8fr_pkg.sv =====
// ----------------------------------------------------------------------------
// crc8fr_pkg
// Types, codes and the CRC-8 byte step shared by the frame receiver modules.
// ----------------------------------------------------------------------------
package crc8fr_pkg;

    // Operation codes carried in s_tuser
    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_ARM  = 2'd2;

    // Frame status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_NO_RESPONSE = 3'd1;
    localparam logic [2:0] ST_TOO_LONG    = 3'd2;
    localparam logic [2:0] ST_CHECKSUM    = 3'd3;
    localparam logic [2:0] ST_TOO_MANY    = 3'd4;
    localparam logic [2:0] ST_TOO_FEW     = 3'd5;

    // Result kinds carried in m_tuser
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_MAX_FRAME_BYTES     = 2'd0;
    localparam logic [1:0] REG_FRAME_TIMEOUT_TICKS = 2'd1;
    localparam logic [1:0] REG_RESPONSE_WAIT_TICKS = 2'd2;

    localparam logic [7:0]  RST_MAX_FRAME_BYTES     = 8'd255;
    localparam logic [15:0] RST_FRAME_TIMEOUT_TICKS = 16'd1000;
    localparam logic [15:0] RST_RESPONSE_WAIT_TICKS = 16'd1000;

    localparam logic [7:0]  CRC_POLY = 8'h8C;
    localparam logic [7:0]  CRC_INIT = 8'h00;
    localparam logic [15:0] TICK_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_ARMED = 2'd1,
        PH_RECV  = 2'd2,
        PH_FLUSH = 2'd3
    } phase_t;

    typedef struct packed {
        logic [7:0]  max_frame_bytes;
        logic [15:0] frame_timeout_ticks;
        logic [15:0] response_wait_ticks;
    } cfg_t;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data_byte;
        logic       more_waiting;
    } item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] payload_byte;
        logic [2:0] status;
        logic [7:0] payload_length;
    } result_t;

    // Reflected CRC-8, one byte, LSB first
    function automatic logic [7:0] crc8_step(input logic [7:0] crc_in,
                                             input logic [7:0] data_in);
        logic [7:0] c;
        logic [7:0] d;
        logic       mix;
        c = crc_in;
        d = data_in;
        for (int i = 0; i < 8; i++)
        begin
            mix = c[0] ^ d[0];
            c   = {1'b0, c[7:1]};
            if (mix)
            begin
                c = c ^ CRC_POLY;
            end
            d = {1'b0, d[7:1]};
        end
        return c;
    endfunction

endpackage

// ===== design/crc8_frame_receiver_top.sv =====
// ----------------------------------------------------------------------------
// crc8_frame_receiver_top
// Length-prefixed serial frame receiver with reflected CRC-8 check.
// ----------------------------------------------------------------------------
// Takes one transaction per clock: a received byte, a time tick or an arm
// request. Each transaction lands in an input register, is decoded against
// the frame state in one pass of logic, and its result (a payload byte or a
// final frame status), if it has one, goes to the result register, which
// drives m_tvalid. Sustained rate is one transaction per cycle, set by that
// single decode stage; when m_tready stays low the result register holds, the
// input register fills and s_tready drops.
module crc8_frame_receiver_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [7:0] data_byte, [8] more_waiting
    input  logic [1:0]  s_tuser,    // [1:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [7:0] payload_byte, [10:8] status,
                                    // [18:11] payload_length
    output logic        m_tuser,    // [0] kind
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    crc8fr_pkg::cfg_t    cfg;
    crc8fr_pkg::item_t   in_item_reg;
    logic                in_valid_reg;
    logic                in_valid_next;
    logic                advance;
    logic                out_free;
    logic                res_valid;
    crc8fr_pkg::result_t res;
    logic                s_accept;

    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_item_reg.op           <= s_tuser;
            in_item_reg.data_byte    <= s_tdata[7:0];
            in_item_reg.more_waiting <= s_tdata[8];
        end
    end

    crc8fr_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    crc8fr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item      (in_item_reg),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    crc8fr_out_stage u_out
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance && res_valid),
        .res      (res),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== design/crc8fr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// crc8fr_cfg_regs
// Write-only configuration registers: frame size limit and tick limits.
// ----------------------------------------------------------------------------
module crc8fr_cfg_regs
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output crc8fr_pkg::cfg_t    cfg
);

    crc8fr_pkg::cfg_t cfg_reg;
    crc8fr_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                crc8fr_pkg::REG_MAX_FRAME_BYTES:
                    cfg_next.max_frame_bytes = cfg_data[7:0];
                crc8fr_pkg::REG_FRAME_TIMEOUT_TICKS:
                    cfg_next.frame_timeout_ticks = cfg_data;
                crc8fr_pkg::REG_RESPONSE_WAIT_TICKS:
                    cfg_next.response_wait_ticks = cfg_data;
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_frame_bytes     <= crc8fr_pkg::RST_MAX_FRAME_BYTES;
            cfg_reg.frame_timeout_ticks <= crc8fr_pkg::RST_FRAME_TIMEOUT_TICKS;
            cfg_reg.response_wait_ticks <= crc8fr_pkg::RST_RESPONSE_WAIT_TICKS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/crc8fr_ctrl.sv =====
// ----------------------------------------------------------------------------
// crc8fr_ctrl
// Frame state, counters and CRC; decides the result of each transaction.
// ----------------------------------------------------------------------------
module crc8fr_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  crc8fr_pkg::item_t     item,
    input  crc8fr_pkg::cfg_t      cfg,
    output logic                  res_valid,
    output crc8fr_pkg::result_t   res
);

    crc8fr_pkg::phase_t phase_reg;
    crc8fr_pkg::phase_t phase_next;
    logic [7:0]         expected_count_reg;
    logic [7:0]         expected_count_next;
    logic [7:0]         received_count_reg;
    logic [7:0]         received_count_next;
    logic [7:0]         crc_acc_reg;
    logic [7:0]         crc_acc_next;
    logic [15:0]        tick_count_reg;
    logic [15:0]        tick_count_next;

    logic [15:0] tick_inc;
    logic [7:0]  rcv_inc;
    logic [7:0]  crc_upd;
    logic        in_payload;

    assign tick_inc   = (tick_count_reg == crc8fr_pkg::TICK_MAX) ?
                        tick_count_reg : tick_count_reg + 16'd1;
    assign rcv_inc    = received_count_reg + 8'd1;
    assign in_payload = rcv_inc < expected_count_reg;
    assign crc_upd    = crc8fr_pkg::crc8_step(crc_acc_reg, item.data_byte);

    // Next state and counters
    always_comb
    begin
        phase_next          = phase_reg;
        expected_count_next = expected_count_reg;
        received_count_next = received_count_reg;
        crc_acc_next        = crc_acc_reg;
        tick_count_next     = tick_count_reg;
        case (item.op)
            crc8fr_pkg::OP_ARM:
            begin
                if (phase_reg != crc8fr_pkg::PH_FLUSH)
                begin
                    phase_next      = crc8fr_pkg::PH_ARMED;
                    tick_count_next = 16'd0;
                end
            end
            crc8fr_pkg::OP_TICK:
            begin
                if (phase_reg == crc8fr_pkg::PH_ARMED)
                begin
                    tick_count_next = tick_inc;
                    if (tick_inc >= cfg.response_wait_ticks)
                    begin
                        phase_next = crc8fr_pkg::PH_IDLE;
                    end
                end
                else if (phase_reg == crc8fr_pkg::PH_RECV)
                begin
                    tick_count_next = tick_inc;
                    if (tick_inc >= cfg.frame_timeout_ticks)
                    begin
                        phase_next = crc8fr_pkg::PH_IDLE;
                    end
                end
            end
            crc8fr_pkg::OP_BYTE:
            begin
                case (phase_reg)
                    crc8fr_pkg::PH_FLUSH:
                    begin
                        if (!item.more_waiting)
                        begin
                            phase_next = crc8fr_pkg::PH_IDLE;
                        end
                    end
                    crc8fr_pkg::PH_RECV:
                    begin
                        received_count_next = rcv_inc;
                        if (in_payload)
                        begin
                            crc_acc_next = crc_upd;
                        end
                        else if (item.more_waiting)
                        begin
                            phase_next = crc8fr_pkg::PH_FLUSH;
                        end
                        else
                        begin
                            phase_next = crc8fr_pkg::PH_IDLE;
                        end
                    end
                    default:
                    begin
                        // length byte
                        if (item.data_byte > cfg.max_frame_bytes ||
                            item.data_byte == 8'd0)
                        begin
                            phase_next = crc8fr_pkg::PH_IDLE;
                        end
                        else
                        begin
                            phase_next          = crc8fr_pkg::PH_RECV;
                            expected_count_next = item.data_byte;
                            received_count_next = 8'd0;
                            crc_acc_next        = crc8fr_pkg::CRC_INIT;
                            tick_count_next     = 16'd0;
                        end
                    end
                endcase
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    // Result
    always_comb
    begin
        res_valid          = 1'b0;
        res.kind           = crc8fr_pkg::KIND_STATUS;
        res.payload_byte   = 8'd0;
        res.status         = crc8fr_pkg::ST_OK;
        res.payload_length = 8'd0;
        case (item.op)
            crc8fr_pkg::OP_TICK:
            begin
                if (phase_reg == crc8fr_pkg::PH_ARMED &&
                    tick_inc >= cfg.response_wait_ticks)
                begin
                    res_valid  = 1'b1;
                    res.status = crc8fr_pkg::ST_NO_RESPONSE;
                end
                else if (phase_reg == crc8fr_pkg::PH_RECV &&
                         tick_inc >= cfg.frame_timeout_ticks)
                begin
                    res_valid  = 1'b1;
                    res.status = (received_count_reg == 8'd0) ?
                                 crc8fr_pkg::ST_NO_RESPONSE : crc8fr_pkg::ST_TOO_FEW;
                end
            end
            crc8fr_pkg::OP_BYTE:
            begin
                case (phase_reg)
                    crc8fr_pkg::PH_FLUSH:
                    begin
                        res_valid = 1'b0;
                    end
                    crc8fr_pkg::PH_RECV:
                    begin
                        res_valid = 1'b1;
                        if (in_payload)
                        begin
                            res.kind         = crc8fr_pkg::KIND_PAYLOAD;
                            res.payload_byte = item.data_byte;
                        end
                        else if (item.more_waiting)
                        begin
                            res.status = crc8fr_pkg::ST_TOO_MANY;
                        end
                        else if (crc_acc_reg == item.data_byte)
                        begin
                            res.status         = crc8fr_pkg::ST_OK;
                            res.payload_length = expected_count_reg - 8'd1;
                        end
                        else
                        begin
                            res.status = crc8fr_pkg::ST_CHECKSUM;
                        end
                    end
                    default:
                    begin
                        if (item.data_byte > cfg.max_frame_bytes)
                        begin
                            res_valid  = 1'b1;
                            res.status = crc8fr_pkg::ST_TOO_LONG;
                        end
                        else if (item.data_byte == 8'd0)
                        begin
                            res_valid  = 1'b1;
                            res.status = crc8fr_pkg::ST_TOO_FEW;
                        end
                    end
                endcase
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= crc8fr_pkg::PH_IDLE;
            expected_count_reg <= 8'd0;
            received_count_reg <= 8'd0;
            crc_acc_reg        <= crc8fr_pkg::CRC_INIT;
            tick_count_reg     <= 16'd0;
        end
        else if (advance)
        begin
            phase_reg          <= phase_next;
            expected_count_reg <= expected_count_next;
            received_count_reg <= received_count_next;
            crc_acc_reg        <= crc_acc_next;
            tick_count_reg     <= tick_count_next;
        end
    end

    // A frame in progress never has counted past its CRC byte
    a_recv_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == crc8fr_pkg::PH_RECV |-> received_count_reg < expected_count_reg)
        else $error("received count reached expected count while receiving");

    a_payload_phase: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_valid && res.kind == crc8fr_pkg::KIND_PAYLOAD
        |-> phase_reg == crc8fr_pkg::PH_RECV)
        else $error("payload byte produced outside a frame");

    a_flush_entry: assert property (@(posedge clk) disable iff (!rst_n)
        advance && phase_reg != crc8fr_pkg::PH_FLUSH && phase_next == crc8fr_pkg::PH_FLUSH
        |-> res_valid && res.status == crc8fr_pkg::ST_TOO_MANY)
        else $error("flush entered without a too-many status");

    a_ok_length: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res_valid && res.kind == crc8fr_pkg::KIND_STATUS &&
        res.status == crc8fr_pkg::ST_OK
        |=> phase_reg == crc8fr_pkg::PH_IDLE && $past(expected_count_reg) != 8'd0)
        else $error("ok status not followed by idle");

endmodule

// ===== design/crc8fr_out_stage.sv =====
// ----------------------------------------------------------------------------
// crc8fr_out_stage
// Result register on the master side; holds a result until it is taken.
// ----------------------------------------------------------------------------
module crc8fr_out_stage
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  crc8fr_pkg::result_t   res,
    output logic                  free,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,
    output logic                  m_tuser
);

    logic                out_valid_reg;
    logic                out_valid_next;
    crc8fr_pkg::result_t out_res_reg;

    assign free = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.kind;
    assign m_tdata  = {5'd0, out_res_reg.payload_length, out_res_reg.status,
                       out_res_reg.payload_byte};

endmodule
